@@ rtl/rhc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the RGB/HSV pixel converter.
// No dependencies; every other file of the block imports this package.
package rhc_pkg;

  localparam int COMP_W       = 8;
  localparam int NUM_W        = 16;
  localparam int DIV_STEPS    = 8;
  localparam int STEP_W       = $clog2(DIV_STEPS);
  localparam int FRONT_STAGES = 3;
  localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STEPS + 1;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_DIRECTION = '0;

  typedef logic [COMP_W-1:0] comp_t;

  typedef enum logic {
    DIR_TO_HSV = 1'b0,
    DIR_TO_RGB = 1'b1
  } dir_t;

  // one lane of the restoring divider: partial remainder, divisor, quotient so far
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    comp_t            den;
    comp_t            quo;
  } div_lane_t;

  // everything that rides alongside the two divider lanes
  typedef struct packed {
    dir_t  dir;
    comp_t v;
    comp_t base;
    logic  neg;
    logic  black;
    logic  grey;
    comp_t rgb_a;
    comp_t rgb_b;
    comp_t rgb_c;
  } side_t;

  typedef struct packed {
    div_lane_t sat;
    div_lane_t hue;
    side_t     side;
  } div_word_t;

endpackage

@@ rtl/rhc_regs.sv @@
`timescale 1ns / 1ps
// APB-style register slave holding the conversion direction.
// Depends on rhc_pkg.
module rhc_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rhc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rhc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rhc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output rhc_pkg::dir_t                   direction
);
  import rhc_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_TO_HSV;
    end else if (wr_en && (reg_idx == REG_DIRECTION)) begin
      direction <= dir_t'(pwdata[0]);
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DIRECTION: prdata = APB_DATA_W'(direction);
      default:       prdata = '0;
    endcase
  end

endmodule

@@ rtl/rhc_front.sv @@
`timescale 1ns / 1ps
// Front end: three pipeline stages that prepare divider operands (RGB to HSV)
// and finish the whole HSV to RGB conversion. Depends on rhc_pkg.
module rhc_front (
  input  logic               clk,
  input  logic               rst,
  input  rhc_pkg::dir_t      dir,
  input  logic               up_valid,
  output logic               up_ready,
  input  rhc_pkg::comp_t     comp_a,
  input  rhc_pkg::comp_t     comp_b,
  input  rhc_pkg::comp_t     comp_c,
  output logic               dn_valid,
  input  logic               dn_ready,
  output rhc_pkg::div_word_t dn_word
);
  import rhc_pkg::*;

  localparam comp_t HUE_STEP   = 8'd43;
  localparam comp_t BASE_GREEN = 8'd85;
  localparam comp_t BASE_BLUE  = 8'd171;
  localparam comp_t FULL_SCALE = 8'd255;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_t;

  typedef struct packed {
    dir_t     dir;
    comp_t    a;
    comp_t    b;
    comp_t    c;
    comp_t    mx;
    comp_t    mn;
    max_sel_t msel;
    logic [2:0] region;
    comp_t    rem6;
  } st1_t;

  typedef struct packed {
    dir_t       dir;
    comp_t      mx;
    comp_t      span;
    comp_t      dabs;
    logic       neg;
    comp_t      base;
    comp_t      v;
    logic       s_zero;
    logic [2:0] region;
    logic [NUM_W-1:0] p_s_rem;
    logic [NUM_W-1:0] p_s_inv;
    logic [NUM_W-1:0] p_v_inv;
  } st2_t;

  logic      v1, v2, v3;
  logic      rdy1, rdy2, rdy3;
  st1_t      s1, s1_next;
  st2_t      s2, s2_next;
  div_word_t s3_next;

  assign rdy3     = !v3 || dn_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v3;

  // stage 1: max/min with red-first tie order, hue region and scaled remainder
  always_comb begin
    comp_t      mx;
    comp_t      mn;
    comp_t      off;
    logic [5:0] rem;
    mx = comp_a;
    if (comp_b > mx) mx = comp_b;
    if (comp_c > mx) mx = comp_c;
    mn = comp_a;
    if (comp_b < mn) mn = comp_b;
    if (comp_c < mn) mn = comp_c;

    s1_next.dir = dir;
    s1_next.a   = comp_a;
    s1_next.b   = comp_b;
    s1_next.c   = comp_c;
    s1_next.mx  = mx;
    s1_next.mn  = mn;
    if (mx == comp_a)      s1_next.msel = MAX_RED;
    else if (mx == comp_b) s1_next.msel = MAX_GREEN;
    else                   s1_next.msel = MAX_BLUE;

    s1_next.region = 3'd0;
    if (comp_a >= 8'd43)  s1_next.region = 3'd1;
    if (comp_a >= 8'd86)  s1_next.region = 3'd2;
    if (comp_a >= 8'd129) s1_next.region = 3'd3;
    if (comp_a >= 8'd172) s1_next.region = 3'd4;
    if (comp_a >= 8'd215) s1_next.region = 3'd5;

    case (s1_next.region)
      3'd0:    off = 8'd0;
      3'd1:    off = 8'd43;
      3'd2:    off = 8'd86;
      3'd3:    off = 8'd129;
      3'd4:    off = 8'd172;
      default: off = 8'd215;
    endcase
    rem          = 6'(comp_a - off);
    s1_next.rem6 = {rem, 2'b00} + {1'b0, rem, 1'b0};
  end

  // stage 2: span, signed hue difference, first HSV products
  always_comb begin
    logic [COMP_W:0] diff;
    case (s1.msel)
      MAX_RED: begin
        s2_next.base = 8'd0;
        diff         = {1'b0, s1.b} - {1'b0, s1.c};
      end
      MAX_GREEN: begin
        s2_next.base = BASE_GREEN;
        diff         = {1'b0, s1.c} - {1'b0, s1.a};
      end
      default: begin
        s2_next.base = BASE_BLUE;
        diff         = {1'b0, s1.a} - {1'b0, s1.b};
      end
    endcase
    s2_next.dir     = s1.dir;
    s2_next.mx      = s1.mx;
    s2_next.span    = s1.mx - s1.mn;
    s2_next.neg     = diff[COMP_W];
    s2_next.dabs    = diff[COMP_W] ? comp_t'((COMP_W+1)'(0) - diff) : diff[COMP_W-1:0];
    s2_next.v       = s1.c;
    s2_next.s_zero  = (s1.b == '0);
    s2_next.region  = s1.region;
    s2_next.p_s_rem = NUM_W'(s1.b) * NUM_W'(s1.rem6);
    s2_next.p_s_inv = NUM_W'(s1.b) * NUM_W'(FULL_SCALE - s1.rem6);
    s2_next.p_v_inv = NUM_W'(s1.c) * NUM_W'(FULL_SCALE - s1.b);
  end

  // stage 3: divider operands; p, q, t and the region swizzle
  always_comb begin
    logic [NUM_W-1:0] q_prod;
    logic [NUM_W-1:0] t_prod;
    comp_t            p_val;
    comp_t            q_val;
    comp_t            t_val;
    q_prod = NUM_W'(s2.v) * NUM_W'(FULL_SCALE - s2.p_s_rem[NUM_W-1:COMP_W]);
    t_prod = NUM_W'(s2.v) * NUM_W'(FULL_SCALE - s2.p_s_inv[NUM_W-1:COMP_W]);
    p_val  = s2.p_v_inv[NUM_W-1:COMP_W];
    q_val  = q_prod[NUM_W-1:COMP_W];
    t_val  = t_prod[NUM_W-1:COMP_W];

    s3_next.sat.rem = {s2.span, 8'd0} - NUM_W'(s2.span);
    s3_next.sat.den = s2.mx;
    s3_next.sat.quo = '0;
    s3_next.hue.rem = NUM_W'(s2.dabs) * NUM_W'(HUE_STEP);
    s3_next.hue.den = s2.span;
    s3_next.hue.quo = '0;

    s3_next.side.dir   = s2.dir;
    s3_next.side.v     = s2.mx;
    s3_next.side.base  = s2.base;
    s3_next.side.neg   = s2.neg;
    s3_next.side.black = (s2.mx == '0);
    s3_next.side.grey  = (s2.span == '0);

    case (s2.region)
      3'd0: begin
        s3_next.side.rgb_a = s2.v;  s3_next.side.rgb_b = t_val; s3_next.side.rgb_c = p_val;
      end
      3'd1: begin
        s3_next.side.rgb_a = q_val; s3_next.side.rgb_b = s2.v;  s3_next.side.rgb_c = p_val;
      end
      3'd2: begin
        s3_next.side.rgb_a = p_val; s3_next.side.rgb_b = s2.v;  s3_next.side.rgb_c = t_val;
      end
      3'd3: begin
        s3_next.side.rgb_a = p_val; s3_next.side.rgb_b = q_val; s3_next.side.rgb_c = s2.v;
      end
      3'd4: begin
        s3_next.side.rgb_a = t_val; s3_next.side.rgb_b = p_val; s3_next.side.rgb_c = s2.v;
      end
      default: begin
        s3_next.side.rgb_a = s2.v;  s3_next.side.rgb_b = p_val; s3_next.side.rgb_c = q_val;
      end
    endcase
    if (s2.s_zero) begin
      s3_next.side.rgb_a = s2.v;
      s3_next.side.rgb_b = s2.v;
      s3_next.side.rgb_c = s2.v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= up_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1      <= s1_next;
    if (rdy2) s2      <= s2_next;
    if (rdy3) dn_word <= s3_next;
  end

endmodule

@@ rtl/rhc_divider.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, two lanes
// (saturation and hue) plus a sideband word. Depends on rhc_pkg.
module rhc_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  rhc_pkg::div_word_t up_word,
  output logic               dn_valid,
  input  logic               dn_ready,
  output rhc_pkg::div_word_t dn_word
);
  import rhc_pkg::*;

  // quotient is known to fit in COMP_W bits, so start at the top bit
  function automatic div_lane_t lane_step(div_lane_t lane, logic [STEP_W-1:0] bit_idx);
    logic [NUM_W-1:0] shifted;
    logic [NUM_W:0]   trial;
    div_lane_t        res;
    shifted = NUM_W'(lane.den) << bit_idx;
    trial   = {1'b0, lane.rem} - {1'b0, shifted};
    res     = lane;
    if (!trial[NUM_W]) begin
      res.rem          = trial[NUM_W-1:0];
      res.quo[bit_idx] = 1'b1;
    end
    return res;
  endfunction

  logic [DIV_STEPS-1:0] vld;
  logic [DIV_STEPS-1:0] vld_in;
  logic [DIV_STEPS-1:0] rdy;
  div_word_t            wrd      [DIV_STEPS];
  div_word_t            wrd_in   [DIV_STEPS];
  div_word_t            wrd_next [DIV_STEPS];

  assign vld_in   = {vld[DIV_STEPS-2:0], up_valid};
  assign up_ready = rdy[0];
  assign dn_valid = vld[DIV_STEPS-1];
  assign dn_word  = wrd[DIV_STEPS-1];

  always_comb begin
    rdy[DIV_STEPS-1] = !vld[DIV_STEPS-1] || dn_ready;
    for (int k = DIV_STEPS - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_comb begin
    wrd_in[0] = up_word;
    for (int k = 1; k < DIV_STEPS; k++) begin
      wrd_in[k] = wrd[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      wrd_next[k]     = wrd_in[k];
      wrd_next[k].sat = lane_step(wrd_in[k].sat, STEP_W'(DIV_STEPS - 1 - k));
      wrd_next[k].hue = lane_step(wrd_in[k].hue, STEP_W'(DIV_STEPS - 1 - k));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (rdy[k]) vld[k] <= vld_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (rdy[k]) wrd[k] <= wrd_next[k];
    end
  end

endmodule

@@ rtl/rgb_hsv_pixel_converter.sv @@
`timescale 1ns / 1ps
// RGB/HSV pixel converter top level: register slave, front end, divider, output stage.
// Depends on rhc_pkg, rhc_regs, rhc_front and rhc_divider.
//
// Usage notes
// - Pixel in: src_valid/src_stall with comp_a/b/c. A beat is taken on a rising edge
//   with src_valid high and src_stall low. Result out: dst_valid/dst_stall with
//   out_a/b/c, same rule; the receiver drives dst_stall.
// - direction (register 0, byte address 0): 0 = RGB to HSV, 1 = HSV to RGB.
//   Change it only while no pixel is in flight. pready is tied high.
// - Throughput: one pixel per clock, sustained while dst_stall is low. A pixel passes 12
//   register stages (3 front, 8 divider, 1 output) before it shows on dst_valid.
//   Depth is set by the eight-step restoring divider, one quotient bit per stage.
// - Every stage has its own valid bit and moves when the one after it can take
//   data, so bubbles close up and src_stall stays low until all 12 stages hold
//   a pixel. While dst_stall is high the output holds its beat unchanged and the
//   stall reaches back stage by stage; nothing is dropped or duplicated.
// - Synchronous reset empties the pipeline (dst_valid low next cycle) and sets
//   the direction to RGB to HSV.
module rgb_hsv_pixel_converter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rhc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rhc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rhc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            src_valid,
  output logic                            src_stall,
  input  rhc_pkg::comp_t                  comp_a,
  input  rhc_pkg::comp_t                  comp_b,
  input  rhc_pkg::comp_t                  comp_c,
  output logic                            dst_valid,
  input  logic                            dst_stall,
  output rhc_pkg::comp_t                  out_a,
  output rhc_pkg::comp_t                  out_b,
  output rhc_pkg::comp_t                  out_c
);
  import rhc_pkg::*;

  dir_t      direction;
  logic      front_ready;
  logic      fd_valid, fd_ready;
  div_word_t fd_word;
  logic      dv_valid, out_ready;
  div_word_t dv_word;
  comp_t     hue_off, hue;
  comp_t     out_a_next, out_b_next, out_c_next;

  rhc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .direction (direction)
  );

  rhc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .dir      (direction),
    .up_valid (src_valid),
    .up_ready (front_ready),
    .comp_a   (comp_a),
    .comp_b   (comp_b),
    .comp_c   (comp_c),
    .dn_valid (fd_valid),
    .dn_ready (fd_ready),
    .dn_word  (fd_word)
  );

  rhc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .up_valid (fd_valid),
    .up_ready (fd_ready),
    .up_word  (fd_word),
    .dn_valid (dv_valid),
    .dn_ready (out_ready),
    .dn_word  (dv_word)
  );

  assign src_stall = !front_ready;
  assign out_ready = !dst_valid || !dst_stall;

  // hue offset truncates toward zero: negate the magnitude quotient, wrap mod 256
  assign hue_off = dv_word.side.neg ? comp_t'(~dv_word.hue.quo + 1'b1) : dv_word.hue.quo;
  assign hue     = dv_word.side.base + hue_off;

  always_comb begin
    case (dv_word.side.dir)
      DIR_TO_HSV: begin
        out_a_next = dv_word.side.grey  ? '0 : hue;
        out_b_next = dv_word.side.black ? '0 : dv_word.sat.quo;
        out_c_next = dv_word.side.v;
      end
      default: begin
        out_a_next = dv_word.side.rgb_a;
        out_b_next = dv_word.side.rgb_b;
        out_c_next = dv_word.side.rgb_c;
      end
    endcase
  end

  // output register: holds the beat while dst_stall is high
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (out_ready) begin
      dst_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_a <= out_a_next;
      out_b <= out_b_next;
      out_c <= out_c_next;
    end
  end

endmodule

@@ rtl/rhc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the pixel converter, bound to the top level.
// Depends on rhc_pkg and rgb_hsv_pixel_converter.
module rhc_checker (
  input logic           clk,
  input logic           rst,
  input logic           src_valid,
  input logic           src_stall,
  input logic           dst_valid,
  input logic           dst_stall,
  input rhc_pkg::comp_t out_a,
  input rhc_pkg::comp_t out_b,
  input rhc_pkg::comp_t out_c
);
  import rhc_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

  logic [CNT_W-1:0] pending, pending_next;
  logic             in_beat, out_beat;

  assign in_beat  = src_valid && !src_stall;
  assign out_beat = dst_valid && !dst_stall;

  always_comb begin
    pending_next = pending;
    if (in_beat && !out_beat) pending_next = pending + 1'b1;
    if (out_beat && !in_beat) pending_next = pending - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  a_reset_empties: assert property (@(posedge clk) rst |=> !dst_valid)
    else $error("result valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(out_a) && $stable(out_b) && $stable(out_c))
    else $error("stalled result changed or vanished");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> pending != '0)
    else $error("result shown with no pixel in flight");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= CNT_W'(PIPE_DEPTH))
    else $error("more pixels in flight than pipeline stages");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    pending == '0 |-> !src_stall)
    else $error("empty pipeline refuses a pixel");

endmodule

bind rgb_hsv_pixel_converter rhc_checker u_checker (.*);

@@ dv/tb_rgb_hsv_pixel_converter.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for rgb_hsv_pixel_converter: directed table, then random pixels
// under three sender/receiver idle mixes. Depends on rhc_pkg and the converter RTL only.
module tb_rgb_hsv_pixel_converter;
  import rhc_pkg::*;

  localparam int CLK_HALF_NS  = 4;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 16;   // a little over the pipeline depth
  localparam int MAX_PRINTED  = 40;

  // conversion constants
  localparam int FULL_SCALE = 255;
  localparam int HUE_STEP   = 43;
  localparam int HUE_BASE_G = 85;
  localparam int HUE_BASE_B = 171;
  localparam int REM_SCALE  = 6;
  localparam int FRAC_SHIFT = 8;

  // register map; the spare index must be ignored by the block
  localparam logic [REG_IDX_W-1:0]  REG_SPARE      = 1'b1;
  localparam logic [APB_ADDR_W-1:0] ADDR_DIRECTION = {REG_DIRECTION, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_SPARE     = {REG_SPARE, 2'b00};

  typedef struct packed {
    comp_t a;
    comp_t b;
    comp_t c;
  } pix_t;

  typedef enum logic {
    ROW_PIXEL = 1'b0,
    ROW_WRITE = 1'b1
  } row_kind_t;

  // one line of the directed table: either a register write or a pixel beat;
  // typed rows carry the answer, the rest go through the predictor
  typedef struct packed {
    row_kind_t              kind;
    logic [APB_ADDR_W-1:0]  addr;
    logic [APB_DATA_W-1:0]  wdata;
    pix_t                   px;
    logic                   typed;
    pix_t                   want;
  } row_t;

  localparam int N_DIRECTED = 25;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  src_valid = 1'b0;
  logic                  src_stall;
  comp_t                 comp_a    = '0;
  comp_t                 comp_b    = '0;
  comp_t                 comp_c    = '0;
  logic                  dst_valid;
  logic                  dst_stall = 1'b0;
  comp_t                 out_a;
  comp_t                 out_b;
  comp_t                 out_c;

  // testbench copy of the direction register, converted pixels still owed by the block
  dir_t cur_dir = DIR_TO_HSV;
  pix_t awaited_pixels[$];
  int   n_failures    = 0;
  int   src_idle_pct  = 0;
  int   dst_stall_pct = 0;

  row_t directed_rows[N_DIRECTED] = '{
    // after reset: RGB to HSV
    '{ROW_PIXEL, '0, '0, '{8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},   // black
    '{ROW_PIXEL, '0, '0, '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0,   8'd0,   8'd255}}, // white
    '{ROW_PIXEL, '0, '0, '{8'd128, 8'd128, 8'd128}, 1'b1, '{8'd0,   8'd0,   8'd128}}, // grey
    '{ROW_PIXEL, '0, '0, '{8'd255, 8'd0,   8'd0},   1'b1, '{8'd0,   8'd255, 8'd255}},
    '{ROW_PIXEL, '0, '0, '{8'd0,   8'd255, 8'd0},   1'b1, '{8'd85,  8'd255, 8'd255}},
    '{ROW_PIXEL, '0, '0, '{8'd0,   8'd0,   8'd255}, 1'b1, '{8'd171, 8'd255, 8'd255}},
    '{ROW_PIXEL, '0, '0, '{8'd255, 8'd0,   8'd255}, 1'b0, '0},  // red/blue tie, hue wraps
    '{ROW_PIXEL, '0, '0, '{8'd255, 8'd255, 8'd0},   1'b0, '0},  // red/green tie
    '{ROW_PIXEL, '0, '0, '{8'd0,   8'd255, 8'd255}, 1'b0, '0},  // green/blue tie
    '{ROW_PIXEL, '0, '0, '{8'd200, 8'd10,  8'd100}, 1'b0, '0},  // negative offset truncates
    '{ROW_PIXEL, '0, '0, '{8'd1,   8'd0,   8'd0},   1'b0, '0},
    '{ROW_WRITE, ADDR_DIRECTION, 32'd1, '0, 1'b0, '0},
    // HSV to RGB
    '{ROW_PIXEL, '0, '0, '{8'd100, 8'd0,   8'd77},  1'b1, '{8'd77,  8'd77,  8'd77}},  // no sat
    '{ROW_PIXEL, '0, '0, '{8'd0,   8'd255, 8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},   // v is 0
    '{ROW_PIXEL, '0, '0, '{8'd255, 8'd255, 8'd255}, 1'b0, '0},  // top of the last region
    '{ROW_PIXEL, '0, '0, '{8'd0,   8'd255, 8'd255}, 1'b0, '0},
    '{ROW_PIXEL, '0, '0, '{8'd42,  8'd200, 8'd180}, 1'b0, '0},
    '{ROW_PIXEL, '0, '0, '{8'd43,  8'd200, 8'd180}, 1'b0, '0},
    '{ROW_PIXEL, '0, '0, '{8'd129, 8'd200, 8'd180}, 1'b0, '0},
    '{ROW_PIXEL, '0, '0, '{8'd172, 8'd200, 8'd180}, 1'b0, '0},
    '{ROW_PIXEL, '0, '0, '{8'd214, 8'd200, 8'd180}, 1'b0, '0},
    '{ROW_WRITE, ADDR_SPARE, 32'd0, '0, 1'b0, '0},              // ignored: stays HSV to RGB
    '{ROW_PIXEL, '0, '0, '{8'd86,  8'd255, 8'd1},   1'b0, '0},
    '{ROW_WRITE, ADDR_DIRECTION, 32'hFFFF_FFFE, '0, 1'b0, '0},  // only bit 0 counts
    '{ROW_PIXEL, '0, '0, '{8'd17,  8'd234, 8'd99},  1'b0, '0}
  };

  rgb_hsv_pixel_converter u_top (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .comp_a    (comp_a),
    .comp_b    (comp_b),
    .comp_c    (comp_c),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .out_a     (out_a),
    .out_b     (out_b),
    .out_c     (out_c)
  );

  always #CLK_HALF_NS clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // value is the largest component; hue base picked by red, green, blue in that
  // order of precedence, offset divided with truncation toward zero, sum wraps
  function automatic pix_t hsv_from_rgb(input pix_t px);
    int   r, g, b, mx, mn, span, diff, base, sat;
    pix_t res;
    r = px.a;
    g = px.b;
    b = px.c;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    res   = '0;
    res.c = comp_t'(mx);
    if (mx == 0) return res;
    sat   = FULL_SCALE * (mx - mn) / mx;
    res.b = comp_t'(sat);
    if (sat == 0) return res;
    span = mx - mn;
    if (mx == r) begin
      base = 0;
      diff = g - b;
    end else if (mx == g) begin
      base = HUE_BASE_G;
      diff = b - r;
    end else begin
      base = HUE_BASE_B;
      diff = r - g;
    end
    res.a = comp_t'(base + (HUE_STEP * diff) / span);
    return res;
  endfunction

  // six hue regions of 43 steps (the last one 41); remainder scaled to 0..252
  function automatic pix_t rgb_from_hsv(input pix_t px);
    int   h, s, v, region, rem, p, q, t;
    pix_t res;
    h = px.a;
    s = px.b;
    v = px.c;
    if (s == 0) return '{px.c, px.c, px.c};
    region = h / HUE_STEP;
    rem    = (h - region * HUE_STEP) * REM_SCALE;
    p = (v * (FULL_SCALE - s)) >> FRAC_SHIFT;
    q = (v * (FULL_SCALE - ((s * rem) >> FRAC_SHIFT))) >> FRAC_SHIFT;
    t = (v * (FULL_SCALE - ((s * (FULL_SCALE - rem)) >> FRAC_SHIFT))) >> FRAC_SHIFT;
    case (region)
      0: res = '{comp_t'(v), comp_t'(t), comp_t'(p)};
      1: res = '{comp_t'(q), comp_t'(v), comp_t'(p)};
      2: res = '{comp_t'(p), comp_t'(v), comp_t'(t)};
      3: res = '{comp_t'(p), comp_t'(q), comp_t'(v)};
      4: res = '{comp_t'(t), comp_t'(p), comp_t'(v)};
      default: res = '{comp_t'(v), comp_t'(p), comp_t'(q)};
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    n_failures++;
    if (n_failures <= MAX_PRINTED) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // result side: check each beat taken, then pick the stall for the next edge
  always @(posedge clk) begin : result_sink
    pix_t want;
    if (!rst) begin
      if (dst_valid && !dst_stall) begin
        if (awaited_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected beat %0d,%0d,%0d", out_a, out_b, out_c));
        end else begin
          want = awaited_pixels.pop_front();
          if (out_a !== want.a)
            report_mismatch($sformatf("out_a got %0d want %0d", out_a, want.a));
          if (out_b !== want.b)
            report_mismatch($sformatf("out_b got %0d want %0d", out_b, want.b));
          if (out_c !== want.c)
            report_mismatch($sformatf("out_c got %0d want %0d", out_c, want.c));
        end
      end
      dst_stall <= (dst_stall_pct != 0) && ($urandom_range(99) < dst_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // one pixel beat: random idle gap first, then hold the beat until taken;
  // the expectation is queued at the accepting edge with the direction then in force
  task automatic send_pixel(input pix_t px, input bit typed, input pix_t typed_want);
    pix_t want;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    comp_a    <= px.a;
    comp_b    <= px.b;
    comp_c    <= px.c;
    do @(posedge clk); while (src_stall);
    if (typed) want = typed_want;
    else if (cur_dir == DIR_TO_HSV) want = hsv_from_rgb(px);
    else want = rgb_from_hsv(px);
    awaited_pixels.push_back(want);
  endtask

  // sender holds off until the pipeline has handed back every pixel
  task automatic wait_until_drained();
    src_valid <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk);
  endtask

  // setup then access phase; register takes the value at the access edge
  task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] data);
    wait_until_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[APB_ADDR_W-1:2] == REG_DIRECTION) cur_dir = dir_t'(data[0]);
  endtask

  // mostly uniform pixels, plus greys, two-way ties, rail values and low saturation
  function automatic pix_t random_pixel();
    pix_t px;
    comp_t x;
    px = '{comp_t'($urandom_range(255)),
           comp_t'($urandom_range(255)),
           comp_t'($urandom_range(255))};
    x  = comp_t'($urandom_range(255));
    case ($urandom_range(9))
      6: px = '{x, x, x};
      7: case ($urandom_range(2))
           0: begin px.a = x; px.b = x; end
           1: begin px.b = x; px.c = x; end
           default: begin px.a = x; px.c = x; end
         endcase
      8: begin
        px.a = $urandom_range(1) ? comp_t'($urandom_range(1)) : comp_t'(254 + $urandom_range(1));
        px.b = $urandom_range(1) ? comp_t'($urandom_range(1)) : comp_t'(254 + $urandom_range(1));
        px.c = $urandom_range(1) ? comp_t'($urandom_range(1)) : comp_t'(254 + $urandom_range(1));
      end
      9: px.b = comp_t'($urandom_range(3));
      default: ;
    endcase
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------------

  localparam int N_PHASES       = 3;
  localparam int CHUNKS         = 4;
  localparam int PIXELS_PER_CHUNK = 67;
  localparam int HOLD_OFF_AT    = 33;

  int src_idle_by_phase[N_PHASES]  = '{36, 63, 0};
  int dst_stall_by_phase[N_PHASES] = '{63, 36, 0};

  initial begin : run
    logic [APB_ADDR_W-1:0] addr;
    logic [APB_DATA_W-1:0] data;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed table, under the first idle mix
    src_idle_pct  = src_idle_by_phase[0];
    dst_stall_pct = dst_stall_by_phase[0];
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].kind == ROW_WRITE)
        write_register(directed_rows[i].addr, directed_rows[i].wdata);
      else
        send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
    end

    // random part: each phase swaps direction a few times, with junk in the upper bits
    // and now and then a write to the spare index, which must leave the mode alone
    for (int ph = 0; ph < N_PHASES; ph++) begin
      src_idle_pct  = src_idle_by_phase[ph];
      dst_stall_pct = dst_stall_by_phase[ph];
      for (int ch = 0; ch < CHUNKS; ch++) begin
        addr    = ($urandom_range(5) == 0) ? ADDR_SPARE : ADDR_DIRECTION;
        data    = $urandom();
        data[0] = ch[0] ^ ph[0];
        write_register(addr, data);
        for (int n = 0; n < PIXELS_PER_CHUNK; n++) begin
          if (ch == 1 && n == HOLD_OFF_AT) wait_until_drained();
          send_pixel(random_pixel(), 1'b0, '0);
        end
      end
    end

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
